>>> design/fcpu_pkg.sv
// ----------------------------------------------------------------------------
// fcpu_pkg
// types, constants and helpers shared by the fly camera pose update block
// ----------------------------------------------------------------------------
`default_nettype none
package fcpu_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 5;
  localparam int ANG_HALF = 23040;
  localparam int ANG_FULL = 46080;
  localparam int ANG_QUARTER = 11520;
  localparam int DEG_TO_RAD = 146409;
  localparam int CORDIC_GAIN = 652032875;
  localparam int UNIT_Q14 = 16384;
  localparam int CW = 34;

  localparam logic [2:0] REG_START_X     = 3'd0;
  localparam logic [2:0] REG_START_Y     = 3'd1;
  localparam logic [2:0] REG_START_Z     = 3'd2;
  localparam logic [2:0] REG_START_YAW   = 3'd3;
  localparam logic [2:0] REG_START_PITCH = 3'd4;
  localparam logic [2:0] REG_PITCH_LIMIT = 3'd5;

  typedef struct packed {
    logic signed [15:0] forward_step;
    logic signed [15:0] right_step;
    logic signed [15:0] up_step;
    logic signed [15:0] yaw_change;
    logic signed [15:0] pitch_change;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_ANGLE,
    ST_LOAD,
    ST_TRIG_START,
    ST_TRIG_WAIT,
    ST_VEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [15:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic              done;
    logic signed [15:0] sin_val;
    logic signed [15:0] cos_val;
  } trig_rsp_t;

  function automatic logic [CW-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [CW-1:0] r;
    case (i)
      5'd0:  r = CW'(843314857);
      5'd1:  r = CW'(497837829);
      5'd2:  r = CW'(263043837);
      5'd3:  r = CW'(133525159);
      5'd4:  r = CW'(67021687);
      5'd5:  r = CW'(33543516);
      5'd6:  r = CW'(16775851);
      5'd7:  r = CW'(8388437);
      5'd8:  r = CW'(4194283);
      5'd9:  r = CW'(2097149);
      default: r = CW'(64'd1 << (30 - i));
    endcase
    return r;
  endfunction

  // wrap a sum of two 16-bit angles into [-180, 180)
  function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (r >= 18'sd23040) r = r - 18'sd46080;
    else if (r < -18'sd23040) r = r + 18'sd46080;
    if (r >= 18'sd23040) r = r - 18'sd46080;
    else if (r < -18'sd23040) r = r + 18'sd46080;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd16384) r = 16'sd16384;
    else if (v < -36'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/fcpu_cordic.sv
// ----------------------------------------------------------------------------
// fcpu_cordic
// iterative rotation cordic, one step per cycle, sine and cosine in q1.14
// ----------------------------------------------------------------------------
`default_nettype none
module fcpu_cordic
  import fcpu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire trig_req_t req,
  output trig_rsp_t      rsp
);

  logic signed [CW-1:0] x, y, z;
  logic [STEP_W-1:0] step;
  logic busy, neg, done;
  logic signed [15:0] a, af;
  logic fold;
  logic signed [CW-1:0] dx, dy, at;
  logic signed [CW-1:0] xr, yr;
  logic signed [35:0] rc, rs;

  always_comb begin
    a = wrap_angle(18'(req.angle));
    fold = 1'b0;
    af = a;
    if (a > 16'sd11520) begin
      af = 16'sd23040 - a;
      fold = 1'b1;
    end else if (a < -16'sd11520) begin
      af = -16'sd23040 - a;
      fold = 1'b1;
    end
    dx = y >>> step;
    dy = x >>> step;
    at = $signed(atan_entry(step));
    xr = x + CW'(32768);
    yr = y + CW'(32768);
    rc = 36'(xr >>> 16);
    rs = 36'(yr >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        x <= CW'(CORDIC_GAIN);
        y <= '0;
        z <= CW'(af) * CW'(DEG_TO_RAD);
        neg <= fold;
      end else if (busy) begin
        if (!z[CW-1]) begin
          x <= x - dx; y <= y + dy; z <= z - at;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + at;
        end
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.sin_val = clamp_unit(rs);
    rsp.cos_val = neg ? -clamp_unit(rc) : clamp_unit(rc);
  end

endmodule
`default_nettype wire

>>> design/fly_camera_pose_update_top.sv
// ----------------------------------------------------------------------------
// fly_camera_pose_update_top
// euler angle fly camera: moves position along front/right/up, updates angles
// and recomputes the unit vectors with a shared cordic and multiplier
// ----------------------------------------------------------------------------
// channel   direction  handshake
// in        in         in_valid / in_stall
// out       out        out_valid / out_stall
// cfg       in         apb write/read, pready high
//
// result raised after accept through move steps (9 products), angle update,
// two cordic runs, 4 vector products and the done state
// the next item is accepted only once the previous result has been taken
// reset and any config register write reload the pose and recompute the vectors
// a held result under out_stall blocks new items
`default_nettype none
module fly_camera_pose_update_top
  import fcpu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic signed [31:0] start_x, start_y, start_z;
  logic signed [15:0] start_yaw;
  logic signed [14:0] start_pitch;
  logic [13:0] pitch_limit;

  logic signed [31:0] pos [3];
  logic signed [15:0] yaw, pitch;
  logic signed [15:0] fv [3];
  logic signed [15:0] rv [3];
  logic signed [15:0] uv [3];
  logic signed [15:0] sy, cy, sp, cp;
  logic signed [39:0] acc;
  in_item_t item;
  logic with_out, load_req, trig_sel;
  logic [3:0] cnt;

  state_t state, state_next;
  trig_req_t treq;
  trig_rsp_t trsp;

  logic wr;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr = psel && penable && pwrite && (ridx <= REG_PITCH_LIMIT);

  always_comb begin
    case (ridx)
      REG_START_X:     prdata = start_x;
      REG_START_Y:     prdata = start_y;
      REG_START_Z:     prdata = start_z;
      REG_START_YAW:   prdata = 32'(start_yaw);
      REG_START_PITCH: prdata = 32'(start_pitch);
      REG_PITCH_LIMIT: prdata = 32'(pitch_limit);
      default:         prdata = '0;
    endcase
  end

  fcpu_cordic u_cordic (.clk(clk), .rst(rst), .req(treq), .rsp(trsp));

  // shared multiplier
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod;
  logic [1:0] ax;
  logic [1:0] term;
  assign ax = cnt[3:2];
  assign term = cnt[1:0];
  assign prod = ma * mb;

  always_comb begin
    ma = '0; mb = '0;
    if (state == ST_MOVE) begin
      case (term)
        2'd0: begin ma = fv[ax]; mb = item.forward_step; end
        2'd1: begin ma = rv[ax]; mb = item.right_step; end
        default: begin ma = uv[ax]; mb = item.up_step; end
      endcase
    end else begin
      case (cnt)
        4'd0: begin ma = cy; mb = cp; end
        4'd1: begin ma = sy; mb = cp; end
        4'd2: begin ma = -cy; mb = sp; end
        default: begin ma = -sy; mb = sp; end
      endcase
    end
  end

  logic signed [39:0] racc;
  logic signed [33:0] npos;
  logic signed [31:0] psat;
  logic signed [16:0] psum;
  logic signed [15:0] pcl, lim;
  logic signed [35:0] vr;
  assign racc = (acc + 40'sd32) >>> 6;
  assign npos = 34'(pos[ax]) + 34'(racc);
  assign psat = (npos > 34'sd2147483647) ? 32'sh7fffffff :
                (npos < -34'sd2147483648) ? 32'sh80000000 : npos[31:0];
  assign vr = 36'((32'(prod) + 32'sd8192) >>> 14);
  assign lim = 16'(pitch_limit);

  always_comb begin
    psum = 17'(pitch) + 17'(item.pitch_change);
    if (psum > 17'sd32767) pcl = 16'sh7fff;
    else if (psum < -17'sd32768) pcl = 16'sh8000;
    else pcl = psum[15:0];
    if (pitch_limit != '0) begin
      if (pcl > lim) pcl = lim;
      else if (pcl < -lim) pcl = -lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_TRIG_START;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    treq.start = 1'b0;
    treq.angle = trig_sel ? pitch : yaw;
    case (state)
      ST_IDLE:       if (load_req || wr) state_next = ST_LOAD;
                     else if (in_valid && !out_valid) state_next = ST_MOVE;
      ST_MOVE:       if (cnt == 4'd11) state_next = ST_ANGLE;
      ST_ANGLE:      state_next = ST_TRIG_START;
      ST_LOAD:       state_next = ST_TRIG_START;
      ST_TRIG_START: begin
        treq.start = 1'b1;
        state_next = ST_TRIG_WAIT;
      end
      ST_TRIG_WAIT:  if (trsp.done) state_next = trig_sel ? ST_VEC : ST_TRIG_START;
      ST_VEC:        if (cnt == 4'd3) state_next = ST_DONE;
      ST_DONE:       state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  assign in_stall = !(state == ST_IDLE && !out_valid && !load_req && !wr);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0; start_y <= '0; start_z <= '0;
      start_yaw <= -16'sd11520; start_pitch <= '0; pitch_limit <= 14'd11392;
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      yaw <= -16'sd11520; pitch <= '0;
      out_valid <= 1'b0; with_out <= 1'b0; load_req <= 1'b0;
      trig_sel <= 1'b0; cnt <= '0; acc <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (wr) begin
        case (ridx)
          REG_START_X:     start_x <= pwdata;
          REG_START_Y:     start_y <= pwdata;
          REG_START_Z:     start_z <= pwdata;
          REG_START_YAW:   start_yaw <= pwdata[15:0];
          REG_START_PITCH: start_pitch <= pwdata[14:0];
          default:         pitch_limit <= pwdata[13:0];
        endcase
        load_req <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0; acc <= '0; trig_sel <= 1'b0;
          if (load_req || wr) begin
            load_req <= 1'b0;
            with_out <= 1'b0;
          end else if (in_valid && !out_valid) begin
            item <= in_data;
            with_out <= 1'b1;
          end
        end
        ST_MOVE: begin
          if (term == 2'd3) begin
            pos[ax] <= psat;
            acc <= '0;
          end else acc <= acc + 40'(prod);
          cnt <= cnt + 1'b1;
        end
        ST_ANGLE: begin
          yaw <= wrap_angle(18'(yaw) + 18'(item.yaw_change));
          pitch <= pcl;
        end
        ST_LOAD: begin
          pos[0] <= start_x; pos[1] <= start_y; pos[2] <= start_z;
          yaw <= wrap_angle(18'(start_yaw));
          pitch <= 16'(start_pitch);
        end
        ST_TRIG_WAIT: begin
          if (trsp.done) begin
            if (!trig_sel) begin
              sy <= trsp.sin_val; cy <= trsp.cos_val;
            end else begin
              sp <= trsp.sin_val; cp <= trsp.cos_val;
            end
            trig_sel <= 1'b1;
            cnt <= '0;
          end
        end
        ST_VEC: begin
          case (cnt)
            4'd0: fv[0] <= clamp_unit(vr);
            4'd1: fv[2] <= clamp_unit(vr);
            4'd2: uv[0] <= clamp_unit(vr);
            default: uv[2] <= clamp_unit(vr);
          endcase
          cnt <= cnt + 1'b1;
        end
        ST_DONE: begin
          fv[1] <= sp; uv[1] <= cp;
          rv[0] <= -sy; rv[1] <= '0; rv[2] <= cy;
          if (with_out) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.pos_x = pos[0]; out_data.pos_y = pos[1]; out_data.pos_z = pos[2];
    out_data.front_x = fv[0]; out_data.front_y = fv[1]; out_data.front_z = fv[2];
    out_data.right_x = rv[0]; out_data.right_y = rv[1]; out_data.right_z = rv[2];
    out_data.up_x = uv[0]; out_data.up_y = uv[1]; out_data.up_z = uv[2];
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("item accepted while result pending");
  assert property (@(posedge clk) disable iff (rst) out_data.right_y == 16'sd0 || !out_valid)
    else $error("right_y nonzero");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && with_out) |=> out_valid)
    else $error("result not raised");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fly camera pose update block: a queue-fed
// driver sends motion items, a predictor computes each new pose, and a
// monitor compares every result field by field under random idling
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import fcpu_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fly_camera_pose_update_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_item_t  motion_q[$];
  out_item_t pose_q[$];
  int        errors = 0;
  int        idle_in_pct = 0;
  int        stall_out_pct = 0;

  // predictor state
  longint start_pos[3];
  longint start_yaw_r;
  longint start_pitch_r;
  longint pitch_lim;
  longint pos[3];
  longint yaw;
  longint pitch;
  longint fv[3];
  longint rv[3];
  longint uv[3];
  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint wrap_deg(longint a);
    longint r;
    r = (a + ANG_HALF) % ANG_FULL;
    if (r < 0) r += ANG_FULL;
    return r - ANG_HALF;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > UNIT_Q14) return UNIT_Q14;
    if (v < -UNIT_Q14) return -UNIT_Q14;
    return v;
  endfunction

  function automatic void cordic_sin_cos(longint deg, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = wrap_deg(deg);
    flip = 1'b0;
    if (a > ANG_QUARTER) begin
      a = ANG_HALF - a;
      flip = 1'b1;
    end else if (a < -ANG_QUARTER) begin
      a = -ANG_HALF - a;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    z = a * DEG_TO_RAD;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = unit_clamp(rnd_shift(x, 16));
    s = unit_clamp(rnd_shift(y, 16));
    if (flip) c = -c;
  endfunction

  function automatic void refresh_axes();
    longint sy, cy, sp, cp;
    cordic_sin_cos(yaw, sy, cy);
    cordic_sin_cos(pitch, sp, cp);
    fv[0] = unit_clamp(rnd_shift(cy * cp, 14));
    fv[1] = sp;
    fv[2] = unit_clamp(rnd_shift(sy * cp, 14));
    rv[0] = -sy;
    rv[1] = 0;
    rv[2] = cy;
    uv[0] = unit_clamp(rnd_shift(-cy * sp, 14));
    uv[1] = cp;
    uv[2] = unit_clamp(rnd_shift(-sy * sp, 14));
  endfunction

  function automatic void reload_pose();
    for (int k = 0; k < 3; k++) pos[k] = start_pos[k];
    yaw = wrap_deg(start_yaw_r);
    pitch = start_pitch_r;
    refresh_axes();
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_START_X:     start_pos[0] = longint'(signed'(v));
      REG_START_Y:     start_pos[1] = longint'(signed'(v));
      REG_START_Z:     start_pos[2] = longint'(signed'(v));
      REG_START_YAW:   start_yaw_r = longint'(signed'(v[15:0]));
      REG_START_PITCH: start_pitch_r = longint'(signed'(v[14:0]));
      REG_PITCH_LIMIT: pitch_lim = longint'(v[13:0]);
      default: return;
    endcase
    reload_pose();
  endfunction

  function automatic out_item_t advance_pose(in_item_t it);
    longint    d, np, p;
    out_item_t r;
    for (int k = 0; k < 3; k++) begin
      d = fv[k] * it.forward_step + rv[k] * it.right_step + uv[k] * it.up_step;
      np = pos[k] + rnd_shift(d, 6);
      if (np > 64'sd2147483647) np = 64'sd2147483647;
      if (np < -64'sd2147483648) np = -64'sd2147483648;
      pos[k] = np;
    end
    yaw = wrap_deg(yaw + it.yaw_change);
    p = pitch + it.pitch_change;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    if (pitch_lim > 0) begin
      if (p > pitch_lim) p = pitch_lim;
      if (p < -pitch_lim) p = -pitch_lim;
    end
    pitch = p;
    refresh_axes();
    r.pos_x = 32'(pos[0]); r.pos_y = 32'(pos[1]); r.pos_z = 32'(pos[2]);
    r.front_x = 16'(fv[0]); r.front_y = 16'(fv[1]); r.front_z = 16'(fv[2]);
    r.right_x = 16'(rv[0]); r.right_y = 16'(rv[1]); r.right_z = 16'(rv[2]);
    r.up_x = 16'(uv[0]); r.up_y = 16'(uv[1]); r.up_z = 16'(uv[2]);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) pose_q.push_back(advance_pose(in_data));
      if (!in_valid || !in_stall) begin
        if (motion_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
          in_valid <= 1'b1;
          in_data <= motion_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t unexpected result pos_x %0d", $time, out_data.pos_x);
          errors++;
        end else begin
          e = pose_q.pop_front();
          check_field("pos_x", e.pos_x, out_data.pos_x);
          check_field("pos_y", e.pos_y, out_data.pos_y);
          check_field("pos_z", e.pos_z, out_data.pos_z);
          check_field("front_x", e.front_x, out_data.front_x);
          check_field("front_y", e.front_y, out_data.front_y);
          check_field("front_z", e.front_z, out_data.front_z);
          check_field("right_x", e.right_x, out_data.right_x);
          check_field("right_y", e.right_y, out_data.right_y);
          check_field("right_z", e.right_z, out_data.right_z);
          check_field("up_x", e.up_x, out_data.up_x);
          check_field("up_y", e.up_y, out_data.up_y);
          check_field("up_z", e.up_z, out_data.up_z);
        end
      end
      out_stall <= ($urandom_range(99) < stall_out_pct);
    end
  end

  task automatic add_motion(int f, int r, int u, int dy, int dp);
    in_item_t it;
    it.forward_step = 16'(f);
    it.right_step = 16'(r);
    it.up_step = 16'(u);
    it.yaw_change = 16'(dy);
    it.pitch_change = 16'(dp);
    motion_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (motion_q.size() > 0 || in_valid || pose_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    repeat (150) @(posedge clk);
  endtask

  task automatic random_regs();
    reg_write(REG_START_X, $urandom);
    reg_write(REG_START_Y, $urandom);
    reg_write(REG_START_Z, $urandom);
    reg_write(REG_START_YAW, $urandom);
    reg_write(REG_START_PITCH, $urandom);
    reg_write(REG_PITCH_LIMIT, ($urandom_range(3) == 0) ? 0 : $urandom_range(11520));
  endtask

  task automatic random_motion(int n);
    int f, r, u, dy, dp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        f = $urandom; r = $urandom; u = $urandom; dy = $urandom; dp = $urandom;
      end else begin
        f = $signed($urandom_range(1024)) - 512;
        r = $signed($urandom_range(1024)) - 512;
        u = $signed($urandom_range(1024)) - 512;
        dy = $signed($urandom_range(2560)) - 1280;
        dp = $signed($urandom_range(2560)) - 1280;
      end
      add_motion(f, r, u, dy, dp);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start_pos = '{0, 0, 0};
    start_yaw_r = -11520;
    start_pitch_r = 0;
    pitch_lim = 11392;
    reload_pose();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, yaw wrap, pitch clamp
    add_motion(0, 0, 0, 0, 0);
    add_motion(32767, 0, 0, 0, 0);
    add_motion(-32768, 0, 0, 0, 0);
    add_motion(0, 32767, 0, 0, 0);
    add_motion(0, -32768, 0, 0, 0);
    add_motion(0, 0, 32767, 0, 0);
    add_motion(0, 0, -32768, 0, 0);
    add_motion(0, 0, 0, 32767, 0);
    add_motion(0, 0, 0, -32768, 0);
    add_motion(0, 0, 0, 23040, 0);
    add_motion(256, 256, 256, 0, 32767);
    add_motion(256, 256, 256, 0, -32768);
    add_motion(-1, -1, -1, -1, -1);
    add_motion(1, 1, 1, 1, 1);
    wait_drained();

    // extreme start pose, no pitch clamp
    reg_write(REG_START_X, 32'h7fffffff);
    reg_write(REG_START_Y, 32'h80000000);
    reg_write(REG_START_Z, 32'h7fff0000);
    reg_write(REG_START_YAW, 32'h00008000);
    reg_write(REG_START_PITCH, 32'h00003fff);
    reg_write(REG_PITCH_LIMIT, 0);
    add_motion(32767, 32767, 32767, 0, 0);
    add_motion(-32768, -32768, -32768, 0, 0);
    add_motion(0, 0, 0, 0, 32767);
    add_motion(0, 0, 0, 32767, 32767);
    add_motion(0, 0, 0, 0, -32768);
    add_motion(0, 0, 0, 0, -32768);
    add_motion(1000, 1000, 1000, 11520, 11520);
    wait_drained();
    reg_write(REG_PITCH_LIMIT, 11520);
    reg_write(REG_START_PITCH, 32'h00004000);
    add_motion(500, -500, 500, 0, 100);
    add_motion(0, 0, 0, 0, 32767);
    add_motion(0, 0, 0, 0, -32768);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 71; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 71; end
        3: begin idle_in_pct = 20; stall_out_pct = 20; end
        default: begin idle_in_pct = 0; stall_out_pct = 0; end
      endcase
      random_regs();
      random_motion(180);
      wait_drained();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
design/fcpu_pkg.sv
design/fcpu_cordic.sv
design/fly_camera_pose_update_top.sv
test/tb_top.sv
